// File: src/assert_macros.svh
// Assertion helpers shared by the ring and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(name, clk, rst, prop, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/cmac_pkg.sv
package cmac_pkg;

  localparam int WINDOW_DEF = 20;
  localparam int ADC_MAX = 1023;

  // divider geometry
  localparam int DNUM_W = 34;
  localparam int DDEN_W = 18;
  localparam int DCNT_W = $clog2(DNUM_W + 1);

  localparam logic [12:0] REF_MV_RESET = 13'd5000;

  // coefficient numerator: (T16-400)*9472 + 65536*125 + 125/2
  localparam logic [13:0] COEF_SLOPE = 14'd9472;
  localparam logic [24:0] COEF_BASE = 25'd4403262;
  localparam int COEF_NUM_W = 25;
  // ceil(2^32 / 125), exact for any 25-bit numerator
  localparam logic [25:0] COEF_RECIP = 26'd34359739;
  localparam int COEF_SHIFT = 32;

  // compensated voltage thresholds, Q.4 mV
  localparam logic [17:0] VC_MIN = 18'd2400;
  localparam logic [17:0] VC_MAX = 18'd52800;
  localparam logic [17:0] SEG1_TOP = 18'd7168;
  localparam logic [17:0] SEG2_TOP = 18'd23312;

  localparam logic [9:0] SLOPE1 = 10'd684;
  localparam logic [9:0] SLOPE2 = 10'd698;
  localparam logic [9:0] SLOPE3 = 10'd530;
  // offsets with the +800 rounding term folded in
  localparam logic [25:0] OFS1_SUB = 26'd102112;
  localparam logic [25:0] OFS2_SUB = 26'd202400;
  localparam logic [25:0] OFS3_ADD = 26'd3645600;
  localparam int COND_NUM_W = 26;
  // ceil(2^37 / 1600), exact for any 26-bit numerator
  localparam logic [26:0] COND_RECIP = 27'd85899346;
  localparam int COND_SHIFT = 37;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NO_SOLUTION = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  typedef struct packed {
    logic [9:0]  adc_sample;
    logic [10:0] temperature_sixteenths;
  } in_t;

  typedef struct packed {
    logic [9:0]  average;
    logic [12:0] voltage_mv;
    logic [1:0]  status;
    logic [14:0] conductivity_us;
  } out_t;

  typedef struct packed {
    logic       start;
    logic [9:0] sample;
  } ring_req_t;

  typedef struct packed {
    logic              start;
    logic [DNUM_W-1:0] num;
    logic [DDEN_W-1:0] den;
    logic [DCNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DNUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: src/cmac_ring.sv
`include "assert_macros.svh"

module cmac_ring #(
  parameter int WINDOW = cmac_pkg::WINDOW_DEF,
  parameter int SUM_W = $clog2(WINDOW * cmac_pkg::ADC_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cmac_pkg::ring_req_t req,
  output logic                done,
  output logic [SUM_W-1:0]    sum
);
  import cmac_pkg::*;

  localparam int POS_W = $clog2(WINDOW);

  logic [9:0]       mem [WINDOW];
  logic [WINDOW-1:0] filled;
  logic [POS_W-1:0] pos;
  logic [9:0]       rd_data;
  logic             rd_filled;
  logic [9:0]       sample_q;
  logic             busy;
  logic [9:0]       old_val;

  // an entry never written since reset reads as zero
  assign old_val = rd_filled ? rd_data : 10'd0;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rd_data <= mem[pos];
    end
    if (busy) begin
      mem[pos] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sample_q <= req.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      pos       <= '0;
      sum       <= '0;
      busy      <= 1'b0;
      done      <= 1'b0;
      rd_filled <= 1'b0;
    end else begin
      busy <= req.start;
      done <= busy;
      if (req.start) begin
        rd_filled <= filled[pos];
      end
      if (busy) begin
        sum         <= sum - SUM_W'(old_val) + SUM_W'(sample_q);
        filled[pos] <= 1'b1;
        pos         <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
      end
    end
  end

  `ASSERT_NEXT(a_update_one_cycle, clk, rst, busy, !busy && done, "ring update overran")
  `ASSERT_HOLDS(a_sum_bound, clk, rst, sum <= SUM_W'(WINDOW * ADC_MAX), "running sum too big")
  `ASSERT_HOLDS(a_pos_bound, clk, rst, pos <= POS_W'(WINDOW - 1), "ring position past end")

endmodule

// File: src/cmac_div.sv
module cmac_div (
  input  logic               clk,
  input  logic               rst,
  input  cmac_pkg::div_req_t req,
  output cmac_pkg::div_rsp_t rsp
);
  import cmac_pkg::*;

  logic [DNUM_W-1:0] numr;
  logic [DNUM_W-1:0] quo;
  logic [DDEN_W-1:0] den;
  logic [DDEN_W-1:0] rem;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DDEN_W:0]   trial;
  logic [DDEN_W:0]   diff;
  logic              fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, numr[DNUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      // align the used bits to the top so iteration starts at the MSB
      numr <= req.num << (DCNT_W'(DNUM_W) - req.nbits);
      den  <= req.den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      numr <= {numr[DNUM_W-2:0], 1'b0};
      rem  <= fits ? diff[DDEN_W-1:0] : trial[DDEN_W-1:0];
      quo  <= {quo[DNUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DCNT_W'(1));
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/conductivity_meter_average_convert.sv
// Steps: ring update, average, voltage scaling, bit-serial division by the
//   compensation coefficient, segment select, conductivity (skipped on nonzero status).
// One reading is in flight at a time. Input is taken again once the
//   result moves into the output register, which then holds it until accepted.
// Reset: ring entries read as zero via per-entry valid bits, sum and position zero,
//   reference 5000 mV; no clearing pass.
`include "assert_macros.svh"

module conductivity_meter_average_convert #(
  parameter int WINDOW = cmac_pkg::WINDOW_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cmac_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cmac_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic [12:0]    cfg_data
);
  import cmac_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * ADC_MAX + 1);

  // sum / WINDOW by reciprocal, exact for every sum below 2^SUM_W
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam longint unsigned AVG_RECIP_FULL =
      ((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SUM_W:0] AVG_RECIP = AVG_RECIP_FULL[SUM_W:0];
  localparam int AVGP_W = 2 * SUM_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RING = 4'd1;
  localparam logic [3:0] S_AVG  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_VCS  = 4'd4;
  localparam logic [3:0] S_VC   = 4'd5;
  localparam logic [3:0] S_SEG  = 4'd6;
  localparam logic [3:0] S_CND  = 4'd7;
  localparam logic [3:0] S_COND = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state;
  logic [12:0] reference_mv;
  logic [10:0] t16;
  logic [9:0]  avg;
  logic [12:0] volts;
  logic [17:0] coef;
  logic [17:0] vc;
  logic [25:0] prod;
  logic [1:0]  seg;
  logic [1:0]  status;
  logic [14:0] cond;

  logic [AVGP_W-1:0]                avg_prod;
  logic [COEF_NUM_W-1:0]            coef_num_q;
  logic [COEF_NUM_W+25:0]           coef_prod;
  logic [COND_NUM_W+26:0]           cond_prod;

  ring_req_t        ring_req;
  logic             ring_done;
  logic [SUM_W-1:0] ring_sum;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [22:0]           volt_prod;
  logic [COEF_NUM_W-1:0] coef_num;
  logic [DNUM_W-1:0]     vc_num;
  logic [9:0]            slope;
  logic [1:0]            seg_c;
  logic [1:0]            status_c;
  logic [COND_NUM_W-1:0] cond_num;
  logic                  out_free;
  logic                  load_out;
  logic                  bad_cond;

  cmac_ring #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_ring (
    .clk  (clk),
    .rst  (rst),
    .req  (ring_req),
    .done (ring_done),
    .sum  (ring_sum)
  );

  cmac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign load_out  = (state == S_OUT) && out_free;
  assign bad_cond  = out_valid && (out_data.status != ST_VALID) &&
                     (out_data.conductivity_us != 15'd0);
  assign volt_prod = avg * reference_mv;
  assign coef_num  = COEF_NUM_W'(t16 * COEF_SLOPE) + COEF_BASE;
  // (volts << 20) + coef/2, rounding to nearest
  assign vc_num    = {1'b0, volts, 20'd0} + DNUM_W'(coef[17:1]);

  always_comb begin
    if (vc < VC_MIN) begin
      status_c = ST_NO_SOLUTION;
    end else if (vc > VC_MAX) begin
      status_c = ST_OUT_OF_RANGE;
    end else begin
      status_c = ST_VALID;
    end
    if (vc <= SEG1_TOP) begin
      seg_c = 2'd0;
    end else if (vc <= SEG2_TOP) begin
      seg_c = 2'd1;
    end else begin
      seg_c = 2'd2;
    end
    case (seg_c)
      2'd0:    slope = SLOPE1;
      2'd1:    slope = SLOPE2;
      default: slope = SLOPE3;
    endcase
  end

  always_comb begin
    case (seg)
      2'd0:    cond_num = prod - OFS1_SUB;
      2'd1:    cond_num = prod - OFS2_SUB;
      default: cond_num = prod + OFS3_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv <= REF_MV_RESET;
    end else if (cfg_write) begin
      reference_mv <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ring_req  <= '0;
      div_req   <= '0;
    end else begin
      ring_req  <= '{start: in_ready && in_valid, sample: in_data.adc_sample};
      // operands are stable while in S_VCS
      div_req   <= '{start: state == S_VCS, num: vc_num, den: coef,
                     nbits: DCNT_W'(DNUM_W)};
      out_valid <= load_out || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t16   <= in_data.temperature_sixteenths;
            state <= S_RING;
          end
        end
        S_RING: begin
          if (ring_done) begin
            avg_prod   <= ring_sum * AVG_RECIP;
            coef_num_q <= coef_num;
            state      <= S_AVG;
          end
        end
        S_AVG: begin
          avg       <= avg_prod[AVG_SHIFT +: 10];
          coef_prod <= coef_num_q * COEF_RECIP;
          state     <= S_MUL;
        end
        S_MUL: begin
          volts <= volt_prod[22:10];
          coef  <= coef_prod[COEF_SHIFT +: 18];
          state <= S_VCS;
        end
        S_VCS: begin
          state <= S_VC;
        end
        S_VC: begin
          if (div_rsp.done) begin
            vc    <= div_rsp.quo[17:0];
            state <= S_SEG;
          end
        end
        S_SEG: begin
          status <= status_c;
          seg    <= seg_c;
          prod   <= slope * vc[15:0];
          state  <= S_CND;
        end
        S_CND: begin
          if (status != ST_VALID) begin
            cond  <= '0;
            state <= S_OUT;
          end else begin
            cond_prod <= cond_num * COND_RECIP;
            state     <= S_COND;
          end
        end
        S_COND: begin
          cond  <= cond_prod[COND_SHIFT +: 15];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data.average         <= avg;
            out_data.voltage_mv      <= volts;
            out_data.status          <= status;
            out_data.conductivity_us <= cond;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_HOLDS(a_div_start_idle, clk, rst, !div_req.start || !div_rsp.busy, "divider busy")
  `ASSERT_NEXT(a_result_loaded, clk, rst, load_out, out_valid && in_ready, "result not loaded")
  `ASSERT_HOLDS(a_status_zero_cond, clk, rst, !bad_cond, "conductivity with bad status")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cmac_pkg::*;

  localparam int RING_DEPTH = 20;
  localparam int SEGMENTS = 9;
  localparam int READINGS_PER_SEGMENT = 195;
  localparam int DIRECTED_ROWS = 25;
  localparam int NO_WRITE = -1;

  // compensated voltage bands, Q.4 mV
  localparam longint VC_FLOOR = 2400;
  localparam longint VC_CEIL = 52800;
  localparam longint BEND1 = 7168;
  localparam longint BEND2 = 23312;

  typedef struct {
    int          ref_write;
    logic [9:0]  sample;
    logic [10:0] temp16;
    bit          typed;
    out_t        want;
  } drive_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_write = 1'b0;
  logic [12:0] cfg_data = '0;

  // predictor state
  logic [9:0] probe_ring [RING_DEPTH];
  longint unsigned probe_sum;
  int ring_slot;
  longint unsigned full_scale_mv;

  out_t pending_readings [$];
  int idle_in_pct = 19;
  int idle_out_pct = 55;
  int errors = 0;
  int readings_sent = 0;
  int ref_settings = 0;
  int status_seen [3] = '{0, 0, 0};

  drive_row_t directed_rows [DIRECTED_ROWS] = '{
    '{NO_WRITE, 10'd0, 11'd0, 1'b1, '{10'd0, 13'd0, ST_NO_SOLUTION, 15'd0}},
    '{NO_WRITE, 10'd1023, 11'd400, 1'b1, '{10'd51, 13'd249, ST_VALID, 15'd1639}},
    '{NO_WRITE, 10'd1023, 11'd2047, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd0, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd1600, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd400, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd1601, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd800, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd1024, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd1023, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd512, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd400, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd240, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd1200, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd2047, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd400, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd16, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd1599, 1'b0, '0},
    '{NO_WRITE, 10'd1023, 11'd400, 1'b0, '0},
    '{NO_WRITE, 10'd0, 11'd400, 1'b0, '0},
    '{NO_WRITE, 10'd0, 11'd2047, 1'b0, '0},
    '{NO_WRITE, 10'd0, 11'd0, 1'b0, '0},
    '{0, 10'd1023, 11'd400, 1'b0, '0},
    '{8191, 10'd512, 11'd400, 1'b0, '0},
    '{1000, 10'd0, 11'd2047, 1'b0, '0}
  };

  conductivity_meter_average_convert u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // moving average, mV conversion, compensation and segment map
  function automatic out_t predict_reading(logic [9:0] sample, logic [10:0] temp16);
    longint unsigned avg, mv, coef, vc, cond;
    longint coef_num;
    logic [1:0] status;
    out_t r;
    probe_sum = probe_sum - probe_ring[ring_slot] + sample;
    probe_ring[ring_slot] = sample;
    ring_slot = (ring_slot + 1 == RING_DEPTH) ? 0 : ring_slot + 1;
    avg = probe_sum / RING_DEPTH;
    mv = (avg * full_scale_mv) >> 10;
    coef_num = 64'sd8192000 + (longint'(temp16) - 400) * 9472;
    coef = (longint'(coef_num) + 62) / 125;
    vc = ((mv << 20) + coef / 2) / coef;
    cond = 0;
    status = ST_VALID;
    if (vc < VC_FLOOR) begin
      status = ST_NO_SOLUTION;
    end else if (vc > VC_CEIL) begin
      status = ST_OUT_OF_RANGE;
    end else if (vc <= BEND1) begin
      cond = (684 * vc - 102912 + 800) / 1600;
    end else if (vc <= BEND2) begin
      cond = (698 * vc - 203200 + 800) / 1600;
    end else begin
      cond = (530 * vc + 3644800 + 800) / 1600;
    end
    r.average = avg[9:0];
    r.voltage_mv = mv[12:0];
    r.status = status;
    r.conductivity_us = cond[14:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_reading(logic [9:0] sample, logic [10:0] temp16, bit typed,
                              out_t typed_want);
    out_t want;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{adc_sample: sample, temperature_sixteenths: temp16};
    do @(posedge clk); while (!in_ready);
    want = predict_reading(sample, temp16);
    if (typed) begin
      want = typed_want;
    end
    pending_readings.push_back(want);
    status_seen[want.status]++;
    readings_sent++;
    @(negedge clk);
  endtask

  // only with nothing in flight
  task automatic load_reference(int value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
    cfg_data <= 13'(value);
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    full_scale_mv = value;
    ref_settings++;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_out_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        note_mismatch("transaction with nothing pending", out_data, 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_data.average !== want.average)
          note_mismatch("average", out_data.average, want.average);
        if (out_data.voltage_mv !== want.voltage_mv)
          note_mismatch("voltage_mv", out_data.voltage_mv, want.voltage_mv);
        if (out_data.status !== want.status)
          note_mismatch("status", out_data.status, want.status);
        if (out_data.conductivity_us !== want.conductivity_us)
          note_mismatch("conductivity_us", out_data.conductivity_us, want.conductivity_us);
      end
    end
  end

  initial begin
    int target, level_left, s, t, refv;
    for (int i = 0; i < RING_DEPTH; i++) probe_ring[i] = '0;
    probe_sum = 0;
    ring_slot = 0;
    full_scale_mv = 5000;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].ref_write != NO_WRITE) begin
        load_reference(directed_rows[i].ref_write);
      end
      send_reading(directed_rows[i].sample, directed_rows[i].temp16,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    level_left = 0;
    target = 0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: refv = 5000;
        1: refv = 0;
        2: refv = 8191;
        3: refv = 1000;
        4: refv = $urandom_range(5000, 1000);
        5: refv = 1;
        6: refv = $urandom_range(8191, 0);
        7: refv = 2600;
        default: refv = 4095;
      endcase
      load_reference(refv);
      case (seg / 3)
        0: begin
          idle_in_pct = 19;
          idle_out_pct = 55;
        end
        1: begin
          idle_in_pct = 55;
          idle_out_pct = 19;
        end
        default: begin
          idle_in_pct = 0;
          idle_out_pct = 0;
        end
      endcase
      for (int n = 0; n < READINGS_PER_SEGMENT; n++) begin
        // slowly drifting level so the average sweeps the whole scale
        if (level_left == 0) begin
          target = $urandom_range(1023);
          level_left = $urandom_range(40, 5);
        end
        level_left--;
        if ($urandom_range(9) == 0) begin
          s = $urandom_range(1023);
        end else begin
          s = target + int'($urandom_range(64)) - 32;
          s = (s < 0) ? 0 : (s > 1023) ? 1023 : s;
        end
        t = ($urandom_range(11) == 0) ? $urandom_range(2047, 1601) : $urandom_range(1600);
        send_reading(10'(s), 11'(t), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);

    $display("Run covered %0d readings under %0d reference settings, three idle mixes.",
             readings_sent, ref_settings);
    $display("Statuses predicted: valid %0d, no solution %0d, out of range %0d.",
             status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cmac_pkg.sv
src/cmac_ring.sv
src/cmac_div.sv
src/conductivity_meter_average_convert.sv
tb/testbench.sv
